/* hdl/oeg_pkg.sv */
// ----------------------------------------------------------------------------
// oeg_pkg
// Shared types, constants and fixed-point helpers of the orthogonality
// energy gradient block.
// ----------------------------------------------------------------------------
package oeg_pkg;

    localparam int FIELD_W      = 32;
    localparam int PROD_W       = 64;
    localparam int CFG_INDEX_W  = 4;
    localparam int FRAC_BITS    = 24;
    localparam int KV_FRAC_BITS = 16;
    localparam int OUT_SHIFT    = 14;

    typedef logic signed [FIELD_W-1:0]  field_t;
    typedef logic        [FIELD_W-1:0]  ufield_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic        [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_STIFFNESS = cfg_index_t'(0);
    localparam cfg_index_t REG_VOLUME    = cfg_index_t'(1);

    localparam ufield_t CFG_RESET = ufield_t'(65536);
    localparam prod_t   ONE_Q24   = prod_t'(1) <<< FRAC_BITS;

    // round half up: floor((x + 2^(s-1)) / 2^s)
    function automatic prod_t rnd_shift(input prod_t x, input int s);
        prod_t bias;
        bias = prod_t'(1) <<< (s - 1);
        return (x + bias) >>> s;
    endfunction

    // clamp to signed w-bit range, w <= FIELD_W
    function automatic field_t sat_to(input prod_t x, input int w);
        prod_t hi;
        prod_t lo;
        prod_t r;
        hi = (prod_t'(1) <<< (w - 1)) - prod_t'(1);
        lo = -hi - prod_t'(1);
        if (x > hi)
            r = hi;
        else if (x < lo)
            r = lo;
        else
            r = x;
        return field_t'(r);
    endfunction

endpackage

/* hdl/oeg_mac3.sv */
// ----------------------------------------------------------------------------
// oeg_mac3
// Rounds three Q.48 products to Q.24, sums them, optionally removes 1.0,
// and saturates the sum to the working width.
// ----------------------------------------------------------------------------
module oeg_mac3 #(
    parameter int SAT_W = 32
) (
    input  oeg_pkg::prod_t [2:0] p,
    input  logic                 sub_one,
    output oeg_pkg::field_t      y
);

    oeg_pkg::prod_t sum;

    always_comb
    begin
        sum = oeg_pkg::rnd_shift(p[0], oeg_pkg::FRAC_BITS)
            + oeg_pkg::rnd_shift(p[1], oeg_pkg::FRAC_BITS)
            + oeg_pkg::rnd_shift(p[2], oeg_pkg::FRAC_BITS);
        if (sub_one)
            sum = sum - oeg_pkg::ONE_Q24;
        y = oeg_pkg::sat_to(sum, SAT_W);
    end

endmodule

/* hdl/orthogonality_energy_gradient.sv */
// ----------------------------------------------------------------------------
// orthogonality_energy_gradient
// Gradient of the orthogonality energy of one affine body, six-stage pipe.
// Throughput: one body per cycle unless out_ready stalls the output; the six
// registered stages are products, dot sums, term products, term sums, scale product, output.
// Reset clears all stage valid bits; stiffness and volume return to 1.0.
// ----------------------------------------------------------------------------
module orthogonality_energy_gradient #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  oeg_pkg::cfg_index_t    cfg_index,
    input  oeg_pkg::ufield_t       cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  oeg_pkg::field_t        a1_x,
    input  oeg_pkg::field_t        a1_y,
    input  oeg_pkg::field_t        a1_z,
    input  oeg_pkg::field_t        a2_x,
    input  oeg_pkg::field_t        a2_y,
    input  oeg_pkg::field_t        a2_z,
    input  oeg_pkg::field_t        a3_x,
    input  oeg_pkg::field_t        a3_y,
    input  oeg_pkg::field_t        a3_z,

    output logic                   out_valid,
    input  logic                   out_ready,
    output oeg_pkg::field_t        g1_x,
    output oeg_pkg::field_t        g1_y,
    output oeg_pkg::field_t        g1_z,
    output oeg_pkg::field_t        g2_x,
    output oeg_pkg::field_t        g2_y,
    output oeg_pkg::field_t        g2_z,
    output oeg_pkg::field_t        g3_x,
    output oeg_pkg::field_t        g3_y,
    output oeg_pkg::field_t        g3_z
);

    localparam int SAT_W = (DATA_WIDTH < 16) ? 16 :
                           (DATA_WIDTH > oeg_pkg::FIELD_W) ? oeg_pkg::FIELD_W : DATA_WIDTH;

    // unique column pairs: (0,0) (0,1) (0,2) (1,1) (1,2) (2,2)
    localparam int NPAIR = 6;
    localparam int PI [NPAIR] = '{0, 0, 0, 1, 1, 2};
    localparam int PJ [NPAIR] = '{0, 1, 2, 1, 2, 2};
    localparam int PIDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    oeg_pkg::ufield_t stiffness_reg;
    oeg_pkg::ufield_t volume_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= oeg_pkg::CFG_RESET;
            volume_reg    <= oeg_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                oeg_pkg::REG_STIFFNESS: stiffness_reg <= cfg_data;
                oeg_pkg::REG_VOLUME:    volume_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || out_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_ready  = en1;
    assign out_valid = v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: column products and k*v
    // ------------------------------------------------------------------
    oeg_pkg::field_t a_in [3][3];

    always_comb
    begin
        a_in[0] = '{a1_x, a1_y, a1_z};
        a_in[1] = '{a2_x, a2_y, a2_z};
        a_in[2] = '{a3_x, a3_y, a3_z};
    end

    oeg_pkg::field_t a1_reg  [3][3];
    oeg_pkg::prod_t  p1_next [NPAIR][3];
    oeg_pkg::prod_t  p1_reg  [NPAIR][3];
    logic [oeg_pkg::PROD_W:0]   kvw1;
    logic [oeg_pkg::PROD_W-1:0] kvp1_next;
    logic [oeg_pkg::PROD_W-1:0] kvp1_reg;

    always_comb
    begin
        for (int p = 0; p < NPAIR; p++)
            for (int c = 0; c < 3; c++)
                p1_next[p][c] = a_in[PI[p]][c] * a_in[PJ[p]][c];
        kvw1      = (oeg_pkg::PROD_W+1)'(stiffness_reg) * (oeg_pkg::PROD_W+1)'(volume_reg);
        kvp1_next = kvw1[oeg_pkg::PROD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            a1_reg   <= a_in;
            p1_reg   <= p1_next;
            kvp1_reg <= kvp1_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: dot products, coefficients, rounded and clamped k*v
    // ------------------------------------------------------------------
    oeg_pkg::field_t  a2_reg    [3][3];
    oeg_pkg::field_t  coef2_next [NPAIR];
    oeg_pkg::field_t  coef2_reg  [NPAIR];
    logic [oeg_pkg::PROD_W:0] kvr2;
    oeg_pkg::ufield_t kv2_next;
    oeg_pkg::ufield_t kv2_reg;

    for (genvar gp = 0; gp < NPAIR; gp++)
    begin : g_dot
        oeg_pkg::prod_t [2:0] dp;
        assign dp = {p1_reg[gp][2], p1_reg[gp][1], p1_reg[gp][0]};
        oeg_mac3 #(.SAT_W(SAT_W)) u_dot (
            .p       (dp),
            .sub_one (PI[gp] == PJ[gp]),
            .y       (coef2_next[gp])
        );
    end

    always_comb
    begin
        kvr2 = ((oeg_pkg::PROD_W+1)'(kvp1_reg)
                + ((oeg_pkg::PROD_W+1)'(1) << (oeg_pkg::KV_FRAC_BITS - 1)))
               >> oeg_pkg::KV_FRAC_BITS;
        if (kvr2 > (oeg_pkg::PROD_W+1)'({oeg_pkg::FIELD_W{1'b1}}))
            kv2_next = {oeg_pkg::FIELD_W{1'b1}};
        else
            kv2_next = kvr2[oeg_pkg::FIELD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            a2_reg    <= a1_reg;
            coef2_reg <= coef2_next;
            kv2_reg   <= kv2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: coefficient times column products
    // ------------------------------------------------------------------
    oeg_pkg::prod_t   q3_next [3][3][3];
    oeg_pkg::prod_t   q3_reg  [3][3][3];
    oeg_pkg::ufield_t kv3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
                for (int j = 0; j < 3; j++)
                    q3_next[i][c][j] = coef2_reg[PIDX[i][j]] * a2_reg[j][c];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            q3_reg  <= q3_next;
            kv3_reg <= kv2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: term sums
    // ------------------------------------------------------------------
    oeg_pkg::field_t  term4_next [3][3];
    oeg_pkg::field_t  term4_reg  [3][3];
    oeg_pkg::ufield_t kv4_reg;

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_row
        for (genvar gc = 0; gc < 3; gc++)
        begin : g_col
            oeg_pkg::prod_t [2:0] tp;
            assign tp = {q3_reg[gi][gc][2], q3_reg[gi][gc][1], q3_reg[gi][gc][0]};
            oeg_mac3 #(.SAT_W(SAT_W)) u_term (
                .p       (tp),
                .sub_one (1'b0),
                .y       (term4_next[gi][gc])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            term4_reg <= term4_next;
            kv4_reg   <= kv3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: scale by k*v
    // ------------------------------------------------------------------
    logic signed [oeg_pkg::PROD_W:0] sw5 [3][3];
    oeg_pkg::prod_t r5_next [3][3];
    oeg_pkg::prod_t r5_reg  [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
            begin
                sw5[i][c] = (oeg_pkg::PROD_W+1)'(term4_reg[i][c])
                          * (oeg_pkg::PROD_W+1)'($signed({1'b0, kv4_reg}));
                r5_next[i][c] = sw5[i][c][oeg_pkg::PROD_W-1:0];
            end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
            r5_reg <= r5_next;
    end

    // ------------------------------------------------------------------
    // stage 6: round, saturate, output register
    // ------------------------------------------------------------------
    oeg_pkg::field_t g6_next [3][3];
    oeg_pkg::field_t g6_reg  [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
                g6_next[i][c] = oeg_pkg::sat_to(
                    oeg_pkg::rnd_shift(r5_reg[i][c], oeg_pkg::OUT_SHIFT), SAT_W);
    end

    always_ff @(posedge clk)
    begin
        if (en6)
            g6_reg <= g6_next;
    end

    assign g1_x = g6_reg[0][0];
    assign g1_y = g6_reg[0][1];
    assign g1_z = g6_reg[0][2];
    assign g2_x = g6_reg[1][0];
    assign g2_y = g6_reg[1][1];
    assign g2_z = g6_reg[1][2];
    assign g3_x = g6_reg[2][0];
    assign g3_y = g6_reg[2][1];
    assign g3_z = g6_reg[2][2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_mid_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !en4 |=> v3_reg && $stable(kv3_reg))
        else $error("stalled stage lost its beat");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && out_ready && !v5_reg |=> !out_valid)
        else $error("output beat repeated");

endmodule

/* tb/sv/oeg_gradient_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oeg_gradient_checker
// Watches the config, body and gradient channels of the orthogonality energy
// gradient block. Each accepted body is turned into its expected gradient by
// a fixed-point predictor. Each gradient beat is compared field by field with
// the oldest expected gradient.
// ----------------------------------------------------------------------------
module oeg_gradient_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  oeg_pkg::cfg_index_t cfg_index,
    input  oeg_pkg::ufield_t    cfg_data,

    input  logic                in_valid,
    input  logic                in_ready,
    input  oeg_pkg::field_t     a1_x,
    input  oeg_pkg::field_t     a1_y,
    input  oeg_pkg::field_t     a1_z,
    input  oeg_pkg::field_t     a2_x,
    input  oeg_pkg::field_t     a2_y,
    input  oeg_pkg::field_t     a2_z,
    input  oeg_pkg::field_t     a3_x,
    input  oeg_pkg::field_t     a3_y,
    input  oeg_pkg::field_t     a3_z,

    input  logic                out_valid,
    input  logic                out_ready,
    input  oeg_pkg::field_t     g1_x,
    input  oeg_pkg::field_t     g1_y,
    input  oeg_pkg::field_t     g1_z,
    input  oeg_pkg::field_t     g2_x,
    input  oeg_pkg::field_t     g2_y,
    input  oeg_pkg::field_t     g2_z,
    input  oeg_pkg::field_t     g3_x,
    input  oeg_pkg::field_t     g3_y,
    input  oeg_pkg::field_t     g3_z,

    output int                  failures,
    output int                  pending
);

    localparam int NF    = 9;
    localparam int FW    = oeg_pkg::FIELD_W;
    localparam int SAT_W = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);

    typedef logic [NF*FW-1:0] vec9_t;

    oeg_pkg::ufield_t stiffness_q;
    oeg_pkg::ufield_t volume_q;
    vec9_t   expected_grads [$];
    string   grad_names [NF] = '{"g1_x", "g1_y", "g1_z", "g2_x", "g2_y", "g2_z",
                                 "g3_x", "g3_y", "g3_z"};

    function automatic longint round_shr(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_w(input longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAT_W - 1)) - longint'(1);
        lo = -hi - longint'(1);
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    function automatic vec9_t predict_gradient(input vec9_t body);
        longint             col [3][3];
        longint             coef [3][3];
        longint             term [3][3];
        longint             acc;
        longint unsigned    kv_wide;
        longint             kv;
        vec9_t              grad;
        int                 i;
        int                 j;
        int                 c;
        grad = '0;
        for (i = 0; i < 3; i++)
            for (c = 0; c < 3; c++)
                col[i][c] = longint'($signed(body[(i*3+c)*FW +: FW]));
        // Gram entries, identity removed on the diagonal
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
            begin
                acc = 0;
                for (c = 0; c < 3; c++)
                    acc += round_shr(col[i][c] * col[j][c], oeg_pkg::FRAC_BITS);
                if (i == j)
                    acc -= longint'(1) <<< oeg_pkg::FRAC_BITS;
                coef[i][j] = clamp_w(acc);
            end
        for (i = 0; i < 3; i++)
            for (c = 0; c < 3; c++)
            begin
                acc = 0;
                for (j = 0; j < 3; j++)
                    acc += round_shr(coef[i][j] * col[j][c], oeg_pkg::FRAC_BITS);
                term[i][c] = clamp_w(acc);
            end
        kv_wide = (64'(stiffness_q) * 64'(volume_q)
                   + (64'd1 << (oeg_pkg::KV_FRAC_BITS - 1))) >> oeg_pkg::KV_FRAC_BITS;
        if (kv_wide > 64'h0000_0000_FFFF_FFFF)
            kv_wide = 64'h0000_0000_FFFF_FFFF;
        kv = longint'(kv_wide);
        // factor 4 and Q.40 -> Q.24 folded into the final shift
        for (i = 0; i < 3; i++)
            for (c = 0; c < 3; c++)
                grad[(i*3+c)*FW +: FW] =
                    oeg_pkg::field_t'(clamp_w(round_shr(term[i][c] * kv,
                                                        oeg_pkg::OUT_SHIFT)));
        return grad;
    endfunction

    initial
    begin
        failures    = 0;
        pending     = 0;
        stiffness_q = oeg_pkg::CFG_RESET;
        volume_q    = oeg_pkg::CFG_RESET;
    end

    always @(posedge clk)
    begin : monitor
        vec9_t got;
        vec9_t want;
        int    k;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    oeg_pkg::REG_STIFFNESS: stiffness_q = cfg_data;
                    oeg_pkg::REG_VOLUME:    volume_q    = cfg_data;
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
                expected_grads.push_back(predict_gradient(
                    {a3_z, a3_y, a3_x, a2_z, a2_y, a2_x, a1_z, a1_y, a1_x}));
            if (out_valid && out_ready)
            begin
                got = {g3_z, g3_y, g3_x, g2_z, g2_y, g2_x, g1_z, g1_y, g1_x};
                if (expected_grads.size() == 0)
                begin
                    $error("gradient beat with no body pending");
                    failures++;
                end
                else
                begin
                    want = expected_grads.pop_front();
                    for (k = 0; k < NF; k++)
                        if (got[k*FW +: FW] !== want[k*FW +: FW])
                        begin
                            $error("%s: expected %0d, got %0d", grad_names[k],
                                   $signed(want[k*FW +: FW]),
                                   $signed(got[k*FW +: FW]));
                            failures++;
                        end
                end
            end
            pending = expected_grads.size();
        end
    end

endmodule

/* tb/sv/tb_orthogonality_energy_gradient.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_orthogonality_energy_gradient
// Drives affine bodies and stiffness/volume settings into the orthogonality
// energy gradient block: directed corner bodies first, then random phases
// under extreme and typical settings, with random idling on both channels,
// a long output back-pressure stall and drain pauses. Checking is done by
// the gradient checker beside the block.
// ----------------------------------------------------------------------------
module tb_orthogonality_energy_gradient;

    localparam int     DATA_WIDTH     = 32;
    localparam int     NF             = 9;
    localparam int     LATENCY        = 6;
    localparam int     IDLE_PCT       = 11;
    localparam int     RX_HOLD_CYCLES = 120;
    localparam int     PHASES         = 8;
    localparam int     PHASE_BODIES   = 231;
    localparam int     HOLD_BODIES    = 48;
    localparam int     CYCLE_LIMIT    = 200000;
    localparam oeg_pkg::field_t ONE_Q = oeg_pkg::field_t'(1) <<< oeg_pkg::FRAC_BITS;
    localparam oeg_pkg::field_t F_MAX = oeg_pkg::field_t'(32'h7FFF_FFFF);
    localparam oeg_pkg::field_t F_MIN = oeg_pkg::field_t'(32'h8000_0000);

    typedef logic [NF*oeg_pkg::FIELD_W-1:0] body_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    oeg_pkg::cfg_index_t cfg_index;
    oeg_pkg::ufield_t    cfg_data;
    logic                in_valid;
    logic                in_ready;
    oeg_pkg::field_t     a1_x, a1_y, a1_z, a2_x, a2_y, a2_z, a3_x, a3_y, a3_z;
    logic                out_valid;
    logic                out_ready;
    oeg_pkg::field_t     g1_x, g1_y, g1_z, g2_x, g2_y, g2_z, g3_x, g3_y, g3_z;
    int                  failures;
    int                  pending;
    bit                  tx_quiet;
    bit                  rx_quiet;
    int                  hold_asks;
    int                  cycle_count;

    orthogonality_energy_gradient #(.DATA_WIDTH(DATA_WIDTH)) u_dut (.*);

    oeg_gradient_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic body_t pack_body(
        input oeg_pkg::field_t x1, input oeg_pkg::field_t y1, input oeg_pkg::field_t z1,
        input oeg_pkg::field_t x2, input oeg_pkg::field_t y2, input oeg_pkg::field_t z2,
        input oeg_pkg::field_t x3, input oeg_pkg::field_t y3, input oeg_pkg::field_t z3);
        return {z3, y3, x3, z2, y2, x2, z1, y1, x1};
    endfunction

    function automatic body_t random_body();
        body_t           b;
        int              kind;
        int              rot;
        int              axis;
        int              i;
        int              c;
        bit              flip;
        oeg_pkg::field_t v;
        b    = '0;
        kind = $urandom_range(0, 99);
        rot  = $urandom_range(0, 2);
        flip = 1'($urandom_range(0, 1));
        for (i = 0; i < 3; i++)
            for (c = 0; c < 3; c++)
            begin
                if (kind < 40)
                begin
                    // near a signed permutation: almost orthonormal
                    axis = flip ? (rot + 3 - i) % 3 : (rot + i) % 3;
                    v = oeg_pkg::field_t'($urandom_range(0, 1 << 19))
                      - oeg_pkg::field_t'(1 << 18);
                    if (c == axis)
                        v = $urandom_range(0, 1) ? v + ONE_Q : v - ONE_Q;
                end
                else if (kind < 65)
                    v = oeg_pkg::field_t'($urandom_range(0, 1 << 27))
                      - oeg_pkg::field_t'(1 << 26);
                else if (kind < 80)
                    v = oeg_pkg::field_t'($urandom_range(0, 1 << 29))
                      - oeg_pkg::field_t'(1 << 28);
                else if (kind < 95)
                    v = oeg_pkg::field_t'($urandom());
                else
                begin
                    case ($urandom_range(0, 4))
                        0:       v = F_MAX;
                        1:       v = F_MIN;
                        2:       v = '0;
                        3:       v = ONE_Q;
                        default: v = -ONE_Q;
                    endcase
                end
                b[(i*3+c)*oeg_pkg::FIELD_W +: oeg_pkg::FIELD_W] = v;
            end
        return b;
    endfunction

    function automatic oeg_pkg::ufield_t near_unity();
        return oeg_pkg::ufield_t'($urandom_range(0, 32'h0002_0000));
    endfunction

    task automatic offer_body(input body_t b);
        if (!tx_quiet)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        {a3_z, a3_y, a3_x, a2_z, a2_y, a2_x, a1_z, a1_y, a1_x} <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input oeg_pkg::cfg_index_t idx, input oeg_pkg::ufield_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // gradient side
    initial
    begin : receiver
        int hold_seen;
        int k;
        hold_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                out_ready <= 1'b0;
                for (k = 0; k < RX_HOLD_CYCLES; k++)
                    @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_quiet)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** orthogonality_energy_gradient: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int               p;
        int               n;
        oeg_pkg::ufield_t k_val;
        oeg_pkg::ufield_t v_val;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        hold_asks = 0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= oeg_pkg::REG_STIFFNESS;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        {a3_z, a3_y, a3_x, a2_z, a2_y, a2_x, a1_z, a1_y, a1_x} <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner bodies under reset stiffness and volume
        offer_body('0);
        offer_body(pack_body(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
        offer_body(pack_body(2 * ONE_Q, 0, 0, 0, 2 * ONE_Q, 0, 0, 0, 2 * ONE_Q));
        offer_body({NF{F_MAX}});
        offer_body({NF{F_MIN}});
        offer_body(pack_body(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX));
        offer_body({NF{32'h5555_5555}});
        offer_body({NF{32'hAAAA_AAAA}});
        offer_body({NF{32'hFFFF_FFFF}});
        offer_body({NF{32'h0000_0001}});
        offer_body(pack_body(ONE_Q, 0, 0, ONE_Q, 0, 0, ONE_Q, 0, 0));
        offer_body(pack_body(0, ONE_Q, 0, -ONE_Q, 0, 0, 0, 0, ONE_Q));
        offer_body(pack_body(ONE_Q / 2, 0, 0, 0, ONE_Q / 2, 0, 0, 0, ONE_Q / 2));
        offer_body(pack_body(ONE_Q, ONE_Q, ONE_Q, ONE_Q, -ONE_Q, 0, 0, ONE_Q, -ONE_Q));
        offer_body(pack_body(F_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_body(pack_body(F_MIN, 0, 0, 0, F_MAX, 0, 0, 0, ONE_Q));
        drain_all();

        // writes to indexes beyond the register file must leave k and v alone
        write_reg(oeg_pkg::cfg_index_t'($urandom_range(oeg_pkg::REG_VOLUME + 1,
                                                       (1 << oeg_pkg::CFG_INDEX_W) - 1)),
                  32'hFFFF_FFFF);
        write_reg(oeg_pkg::cfg_index_t'((1 << oeg_pkg::CFG_INDEX_W) - 1), '0);
        repeat (3) offer_body(random_body());
        drain_all();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin k_val = '0;             v_val = $urandom();   end
                1:       begin k_val = 32'hFFFF_FFFF;  v_val = 32'hFFFF_FFFF; end
                2:       begin k_val = 32'h0000_0001;  v_val = 32'h0000_8000; end
                3:       begin k_val = near_unity();   v_val = near_unity();  end
                4:       begin k_val = oeg_pkg::CFG_RESET; v_val = oeg_pkg::CFG_RESET; end
                5:       begin k_val = $urandom();     v_val = $urandom();   end
                6:       begin k_val = near_unity();   v_val = near_unity();  end
                default: begin k_val = $urandom();     v_val = '0;           end
            endcase
            write_reg(oeg_pkg::REG_STIFFNESS, k_val);
            write_reg(oeg_pkg::REG_VOLUME, v_val);
            if (p == 3)
            begin
                // output stall while bodies keep coming
                tx_quiet = 1'b1;
                hold_asks++;
            end
            if (p == 6)
            begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            for (n = 0; n < PHASE_BODIES; n++)
            begin
                if (p == 3 && n == HOLD_BODIES)
                    tx_quiet = 1'b0;
                if (p == 5 && n == PHASE_BODIES / 2)
                    drain_all();
                offer_body(random_body());
            end
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            drain_all();
        end

        if (failures == 0)
            $display("** orthogonality_energy_gradient: PASSED **");
        else
            $display("** orthogonality_energy_gradient: FAILED **");
        $finish;
    end

endmodule
